>>> hdl/lgrs_pkg.sv
package lgrs_pkg;

    localparam int ROW_W = 64;
    localparam int COLS  = 64;

    localparam int NBR_W = 4;

    localparam logic [NBR_W-1:0] BIRTH_CNT   = NBR_W'(3);
    localparam logic [NBR_W-1:0] SURVIVE_CNT = NBR_W'(2);

    typedef logic [ROW_W-1:0] t_row;

endpackage

>>> hdl/lgrs_lane.sv
module lgrs_lane (
    input  logic [7:0] i_nbr,
    input  logic       i_self,
    output logic       o_alive
);

    logic [lgrs_pkg::NBR_W-1:0] cnt;

    always_comb begin
        cnt = '0;
        for (int k = 0; k < 8; k++) begin
            cnt = cnt + lgrs_pkg::NBR_W'(i_nbr[k]);
        end
    end

    assign o_alive = (cnt == lgrs_pkg::BIRTH_CNT) ||
                     ((cnt == lgrs_pkg::SURVIVE_CNT) && i_self);

endmodule

>>> hdl/lgrs_row.sv
module lgrs_row (
    input  lgrs_pkg::t_row i_up,
    input  lgrs_pkg::t_row i_mid,
    input  lgrs_pkg::t_row i_down,
    output lgrs_pkg::t_row o_next
);

    localparam int PAD_W = lgrs_pkg::COLS + 2;

    logic [PAD_W-1:0]          up_p;
    logic [PAD_W-1:0]          mid_p;
    logic [PAD_W-1:0]          down_p;
    logic [lgrs_pkg::COLS-1:0] lane_alive;

    // dead cells padded on both edges
    assign up_p   = {1'b0, i_up[lgrs_pkg::COLS-1:0], 1'b0};
    assign mid_p  = {1'b0, i_mid[lgrs_pkg::COLS-1:0], 1'b0};
    assign down_p = {1'b0, i_down[lgrs_pkg::COLS-1:0], 1'b0};

    for (genvar c = 0; c < lgrs_pkg::COLS; c++) begin : g_lane
        lgrs_lane u_lane (
            .i_nbr   ({up_p[c+2:c], mid_p[c+2], mid_p[c], down_p[c+2:c]}),
            .i_self  (mid_p[c+1]),
            .o_alive (lane_alive[c])
        );
    end

    // merge lanes into the result row
    if (lgrs_pkg::COLS < lgrs_pkg::ROW_W) begin : g_pad
        assign o_next = {{(lgrs_pkg::ROW_W - lgrs_pkg::COLS){1'b0}}, lane_alive};
    end else begin : g_full
        assign o_next = lane_alive;
    end

endmodule

>>> hdl/life_generation_row_stream_core.sv
// Output: a result is presented on the output register in the cycle
//   after the transfer of the input row that causes it.
// Throughput: 1 row per cycle unless stalled; a bottom row gives two
//   results that leave in turn via the one row unit and output register.
// Reset: synchronous, active low; clears held rows and frame position.
module life_generation_row_stream_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [63:0]           i_in_row,
    input  logic                  i_in_last_row,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [63:0]           o_out_row,
    output logic                  o_out_frame_end,
    output logic                  o_out_run_last
);

    lgrs_pkg::t_row r_above, n_above;
    lgrs_pkg::t_row r_mid, n_mid;
    logic           r_seen, n_seen;
    logic           r_pend, n_pend;
    logic           r_out_valid, n_out_valid;
    lgrs_pkg::t_row r_out_row, n_out_row;
    logic           r_out_fe, n_out_fe;
    logic           r_out_rl, n_out_rl;

    lgrs_pkg::t_row row_up, row_mid, row_down, row_next;
    logic           slot_free;
    logic           in_xfer;
    logic           load;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = slot_free && !r_pend;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        if (r_pend) begin
            row_up   = r_above;
            row_mid  = r_mid;
            row_down = '0;
        end else begin
            row_up   = r_above;
            row_mid  = r_seen ? r_mid : i_in_row;
            row_down = r_seen ? i_in_row : '0;
        end
    end

    lgrs_row u_row (
        .i_up   (row_up),
        .i_mid  (row_mid),
        .i_down (row_down),
        .o_next (row_next)
    );

    always_comb begin
        n_above   = r_above;
        n_mid     = r_mid;
        n_seen    = r_seen;
        n_pend    = r_pend;
        n_out_row = r_out_row;
        n_out_fe  = r_out_fe;
        n_out_rl  = r_out_rl;
        load      = 1'b0;

        if (r_pend && slot_free) begin
            load      = 1'b1;
            n_out_row = row_next;
            n_out_fe  = 1'b1;
            n_out_rl  = 1'b1;
            n_pend    = 1'b0;
            n_above   = '0;
            n_mid     = '0;
            n_seen    = 1'b0;
        end else if (in_xfer) begin
            if (!r_seen) begin
                if (i_in_last_row) begin
                    load      = 1'b1;
                    n_out_row = row_next;
                    n_out_fe  = 1'b1;
                    n_out_rl  = 1'b1;
                end else begin
                    n_above = '0;
                    n_mid   = i_in_row;
                    n_seen  = 1'b1;
                end
            end else begin
                load      = 1'b1;
                n_out_row = row_next;
                n_out_fe  = 1'b0;
                n_out_rl  = !i_in_last_row;
                n_above   = r_mid;
                n_mid     = i_in_row;
                n_pend    = i_in_last_row;
            end
        end

        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above     <= '0;
            r_mid       <= '0;
            r_seen      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_above     <= n_above;
            r_mid       <= n_mid;
            r_seen      <= n_seen;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_row <= n_out_row;
        r_out_fe  <= n_out_fe;
        r_out_rl  <= n_out_rl;
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_frame_end = r_out_fe;
    assign o_out_run_last  = r_out_rl;

endmodule

>>> sim/life_generation_row_stream_core_tb.sv
`timescale 1ns / 100ps

module life_generation_row_stream_core_tb;

    localparam int CLK_HALF   = 6;
    localparam int RST_CYCLES = 8;
    localparam int ITEMS      = 1100;
    localparam int QUIET_TAIL = 150;
    localparam int DRAIN_WAIT = 8;
    localparam int CYCLE_CAP  = 400000;
    localparam int REPORT_MAX = 10;
    localparam int N_DIRECTED = 18;

    typedef struct packed {
        lgrs_pkg::t_row row;
        logic           last;
        logic           typed;
        logic [1:0]     n_exp;
        lgrs_pkg::t_row exp0;
        lgrs_pkg::t_row exp1;
    } t_row_item;

    typedef struct packed {
        lgrs_pkg::t_row row;
        logic           frame_end;
        logic           run_last;
    } t_gen_row;

    localparam lgrs_pkg::t_row ONES = {lgrs_pkg::ROW_W{1'b1}};
    localparam lgrs_pkg::t_row ZERO = {lgrs_pkg::ROW_W{1'b0}};

    // directed rows: typed single-row grids, a blinker and a corner block, then untyped rows
    localparam t_row_item DIRECTED [0:N_DIRECTED-1] = '{
        '{ZERO,                  1'b1, 1'b1, 2'd1, ZERO,                  ZERO},
        '{ONES,                  1'b1, 1'b1, 2'd1, 64'h7FFF_FFFF_FFFF_FFFE, ZERO},
        '{ZERO,                  1'b0, 1'b1, 2'd0, ZERO,                  ZERO},
        '{64'h0000_0000_0000_00E0, 1'b0, 1'b1, 2'd1, 64'h0000_0000_0000_0040, ZERO},
        '{ZERO,                  1'b1, 1'b1, 2'd2, 64'h0000_0000_0000_0040,
                                                   64'h0000_0000_0000_0040},
        '{64'h0000_0000_0000_0003, 1'b0, 1'b1, 2'd0, ZERO,                  ZERO},
        '{64'h0000_0000_0000_0003, 1'b0, 1'b1, 2'd1, 64'h0000_0000_0000_0003, ZERO},
        '{ZERO,                  1'b1, 1'b1, 2'd2, 64'h0000_0000_0000_0003, ZERO},
        '{64'h8000_0000_0000_0001, 1'b0, 1'b0, 2'd0, ZERO,                  ZERO},
        '{64'h8000_0000_0000_0001, 1'b0, 1'b0, 2'd0, ZERO,                  ZERO},
        '{64'h8000_0000_0000_0001, 1'b1, 1'b0, 2'd0, ZERO,                  ZERO},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 2'd0, ZERO,                  ZERO},
        '{64'h5555_5555_5555_5555, 1'b0, 1'b0, 2'd0, ZERO,                  ZERO},
        '{ONES,                  1'b0, 1'b0, 2'd0, ZERO,                  ZERO},
        '{ZERO,                  1'b0, 1'b0, 2'd0, ZERO,                  ZERO},
        '{64'hC000_0000_0000_0003, 1'b1, 1'b0, 2'd0, ZERO,                  ZERO},
        '{ONES,                  1'b0, 1'b0, 2'd0, ZERO,                  ZERO},
        '{ONES,                  1'b1, 1'b0, 2'd0, ZERO,                  ZERO}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [63:0] i_in_row = '0;
    logic        i_in_last_row = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [63:0] o_out_row;
    logic        o_out_frame_end;
    logic        o_out_run_last;

    t_row_item      row_plan[$];
    t_gen_row       next_gen_q[$];
    lgrs_pkg::t_row held_above;
    lgrs_pkg::t_row held_middle;
    int             held_count;
    int             rows_accepted;
    int             fail_cnt;
    int             cycle_cnt;
    bit             quiet_tail;

    life_generation_row_stream_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_row        (i_in_row),
        .i_in_last_row   (i_in_last_row),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_row       (o_out_row),
        .o_out_frame_end (o_out_frame_end),
        .o_out_run_last  (o_out_run_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic bit cell_alive(lgrs_pkg::t_row r, int c);
        return (c >= 0 && c < lgrs_pkg::COLS) ? r[c] : 1'b0;
    endfunction

    function automatic lgrs_pkg::t_row next_generation(lgrs_pkg::t_row up,
                                                       lgrs_pkg::t_row mid,
                                                       lgrs_pkg::t_row down);
        lgrs_pkg::t_row res;
        int             n;
        res = '0;
        for (int c = 0; c < lgrs_pkg::COLS; c++) begin
            n = 0;
            for (int d = -1; d <= 1; d++) begin
                n += cell_alive(up, c + d) + cell_alive(down, c + d);
                if (d != 0) begin
                    n += cell_alive(mid, c + d);
                end
            end
            if (n == int'(lgrs_pkg::BIRTH_CNT) ||
                (n == int'(lgrs_pkg::SURVIVE_CNT) && mid[c])) begin
                res[c] = 1'b1;
            end
        end
        return res;
    endfunction

    // advances the held rows by one input row; returns number of rows produced
    function automatic int advance_life(lgrs_pkg::t_row row, bit last,
                                        output lgrs_pkg::t_row gen[2]);
        int n;
        gen[0] = '0;
        gen[1] = '0;
        if (held_count == 0) begin
            if (!last) begin
                held_above  = '0;
                held_middle = row;
                held_count  = 1;
                return 0;
            end
            gen[0] = next_generation('0, row, '0);
            n = 1;
        end else begin
            gen[0] = next_generation(held_above, held_middle, row);
            if (!last) begin
                held_above  = held_middle;
                held_middle = row;
                held_count  = 2;
                return 1;
            end
            gen[1] = next_generation(held_middle, row, '0);
            n = 2;
        end
        held_above  = '0;
        held_middle = '0;
        held_count  = 0;
        return n;
    endfunction

    function automatic lgrs_pkg::t_row random_row();
        lgrs_pkg::t_row a;
        lgrs_pkg::t_row b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return ZERO;
            1: return ONES;
            5, 6: return a & b;
            7: return a | b;
            default: return a;
        endcase
    endfunction

    task automatic build_plan();
        t_row_item it;
        int        len;
        for (int i = 0; i < N_DIRECTED; i++) begin
            row_plan.push_back(DIRECTED[i]);
        end
        while (row_plan.size() < ITEMS) begin
            case ($urandom_range(0, 9))
                0: len = 1;
                8: len = $urandom_range(7, 20);
                9: len = $urandom_range(21, 64);
                default: len = $urandom_range(2, 6);
            endcase
            for (int k = 0; k < len; k++) begin
                it       = '0;
                it.row   = random_row();
                it.last  = (k == len - 1);
                row_plan.push_back(it);
            end
        end
    endtask

    // scoreboard: output compare first, input transfer at the same edge yields later rows
    always @(posedge i_clk) begin
        t_row_item      it;
        t_gen_row       got;
        t_gen_row       want;
        lgrs_pkg::t_row gen[2];
        int             n;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("life_generation_row_stream_core verification failed");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_out_row, o_out_frame_end, o_out_run_last};
            if (next_gen_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= REPORT_MAX) begin
                    $display("unexpected row %h frame_end %0b run_last %0b",
                             got.row, got.frame_end, got.run_last);
                end
            end else begin
                want = next_gen_q.pop_front();
                if (got !== want) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX) begin
                        $display("mismatch exp/got: row %h %h fe %0b %0b rl %0b %0b",
                                 want.row, got.row, want.frame_end, got.frame_end,
                                 want.run_last, got.run_last);
                    end
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            it = row_plan[rows_accepted];
            rows_accepted++;
            n = advance_life(i_in_row, i_in_last_row, gen);
            if (it.typed) begin
                n      = it.n_exp;
                gen[0] = it.exp0;
                gen[1] = it.exp1;
            end
            for (int k = 0; k < n; k++) begin
                want.row       = gen[k];
                want.run_last  = (k == n - 1);
                want.frame_end = i_in_last_row && (k == n - 1);
                next_gen_q.push_back(want);
            end
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        held_above    = '0;
        held_middle   = '0;
        held_count    = 0;
        rows_accepted = 0;
        fail_cnt      = 0;
        cycle_cnt     = 0;
        quiet_tail    = 1'b0;
        build_plan();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int idx = 0; idx < row_plan.size(); idx++) begin
            if (idx == row_plan.size() - QUIET_TAIL) begin
                quiet_tail = 1'b1;
            end
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            i_in_valid    <= 1'b1;
            i_in_row      <= row_plan[idx].row;
            i_in_last_row <= row_plan[idx].last;
            do @(posedge i_clk); while (!o_in_ready);
        end
        i_in_valid <= 1'b0;
        while (next_gen_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_cnt == 0 && next_gen_q.size() == 0) begin
            $display("life_generation_row_stream_core verification clean");
        end else begin
            $display("life_generation_row_stream_core verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/lgrs_pkg.sv
hdl/lgrs_lane.sv
hdl/lgrs_row.sv
hdl/life_generation_row_stream_core.sv
sim/life_generation_row_stream_core_tb.sv
